### rtl/tid_pkg.sv
// ----------------------------------------------------------------------------
// tid_pkg: shared types and constants of the timed input debouncer
// State encoding, result flags of one step and the debounce time reset value.
// ----------------------------------------------------------------------------
package tid_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CodeW = 3;

  localparam logic [TimeW-1:0] DebounceResetUs = TimeW'(500);

  typedef enum logic [CodeW-1:0] {
    StUnknown      = 3'd0,
    StActivating   = 3'd1,
    StActive       = 3'd2,
    StInactivating = 3'd3,
    StInactive     = 3'd4
  } state_e;

  // Outcome of one debounce step.
  typedef struct packed {
    state_e state;      // state after the step
    logic   load_time;  // a state change happened: store the timestamp
    logic   rose;
    logic   fell;
  } step_t;

endpackage

### rtl/tid_step.sv
// ----------------------------------------------------------------------------
// tid_step: next-state logic of the debounce machine
// One subtract, one compare and the five-state transition table.
// ----------------------------------------------------------------------------
module tid_step (
  input  tid_pkg::state_e                 state_i,
  input  logic [tid_pkg::TimeW-1:0]       change_time_i,
  input  logic [tid_pkg::TimeW-1:0]       debounce_time_i,
  input  logic                            raw_level_i,
  input  logic [tid_pkg::TimeW-1:0]       time_us_i,
  output tid_pkg::step_t                  step_o
);

  logic [tid_pkg::TimeW-1:0] elapsed;
  logic                      settled;

  // Elapsed time wraps modulo 2^32.
  assign elapsed = time_us_i - change_time_i;
  assign settled = elapsed > debounce_time_i;

  always_comb begin
    step_o.state     = state_i;
    step_o.load_time = 1'b0;
    step_o.rose      = 1'b0;
    step_o.fell      = 1'b0;
    case (state_i)
      tid_pkg::StActivating: begin
        if (raw_level_i) begin
          if (settled) begin
            step_o.state     = tid_pkg::StActive;
            step_o.load_time = 1'b1;
            step_o.rose      = 1'b1;
          end
        end else begin
          step_o.state     = tid_pkg::StInactive;
          step_o.load_time = 1'b1;
        end
      end
      tid_pkg::StActive: begin
        if (!raw_level_i) begin
          step_o.state     = tid_pkg::StInactivating;
          step_o.load_time = 1'b1;
        end
      end
      tid_pkg::StInactivating: begin
        if (raw_level_i) begin
          step_o.state     = tid_pkg::StActive;
          step_o.load_time = 1'b1;
        end else if (settled) begin
          step_o.state     = tid_pkg::StInactive;
          step_o.load_time = 1'b1;
          step_o.fell      = 1'b1;
        end
      end
      tid_pkg::StInactive: begin
        if (raw_level_i) begin
          step_o.state     = tid_pkg::StActivating;
          step_o.load_time = 1'b1;
        end
      end
      default: begin
        // Unknown (and any unused code): leave only on a high sample.
        if (raw_level_i) begin
          step_o.state     = tid_pkg::StActivating;
          step_o.load_time = 1'b1;
        end else begin
          step_o.state     = tid_pkg::StUnknown;
        end
      end
    endcase
  end

endmodule

### rtl/timed_input_debouncer.sv
// ----------------------------------------------------------------------------
// timed_input_debouncer: five-state level debouncer on timestamped samples
// Input register, one-step debounce logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one raw level sample and
//   its free-running microsecond timestamp per transfer. Output channel
//   (out_valid_o / out_ready_i) returns exactly one result per sample: the
//   debounced level, the state code and one-shot rose / fell flags.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the debounce time in
//   microseconds; it is always ready and should only be used while idle.
// Timing:
//   A sample passes from the input register through the debounce step into
//   the result register, which drives out_valid_o. One sample per cycle is
//   sustained while out_ready_i is high: the debounce step is a 32-bit
//   subtract, a compare and the transition table between the two registers.
// Reset:
//   Both stages empty, machine in the unknown state, debounce time 500 us.
// Stall:
//   When out_ready_i is low the result holds; the input register still takes
//   one more sample, then in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module timed_input_debouncer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tid_pkg::TimeW-1:0]   cfg_data_i,
  // samples
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        raw_level_i,
  input  logic [tid_pkg::TimeW-1:0]   time_us_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_active_o,
  output logic [tid_pkg::CodeW-1:0]   state_code_o,
  output logic                        rose_o,
  output logic                        fell_o
);

  // Debounce time register
  logic [tid_pkg::TimeW-1:0] debounce_q;

  // Input register stage
  logic                      in_vld_q;
  logic                      raw_q;
  logic [tid_pkg::TimeW-1:0] time_q;

  // Machine state
  tid_pkg::state_e           state_q;
  logic [tid_pkg::TimeW-1:0] change_time_q;   // no reset: read only after write

  // Result register stage
  logic                      out_vld_q;
  logic                      active_q;
  logic [tid_pkg::CodeW-1:0] code_q;
  logic                      rose_q;
  logic                      fell_q;

  logic                      out_free;
  logic                      advance;
  tid_pkg::step_t            step;

  // Result slot is free when empty or being drained this cycle.
  assign out_free   = !out_vld_q || out_ready_i;
  // Input register item moves into the result register (state commits here).
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= tid_pkg::DebounceResetUs;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q  <= raw_level_i;
      time_q <= time_us_i;
    end
  end

  tid_step u_step (
    .state_i         (state_q),
    .change_time_i   (change_time_q),
    .debounce_time_i (debounce_q),
    .raw_level_i     (raw_q),
    .time_us_i       (time_q),
    .step_o          (step)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tid_pkg::StUnknown;
    end else if (advance) begin
      state_q <= step.state;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.load_time) begin
      change_time_q <= time_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      active_q <= (step.state == tid_pkg::StActive) ||
                  (step.state == tid_pkg::StInactivating);
      code_q   <= step.state;
      rose_q   <= step.rose;
      fell_q   <= step.fell;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign is_active_o  = active_q;
  assign state_code_o = code_q;
  assign rose_o       = rose_q;
  assign fell_o       = fell_q;

`ifndef NO_ASSERTIONS
  // Machine state only moves when an item passes into the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

  // A result never carries both events.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(rose_q && fell_q))
    else $error("rose and fell together");

  // A rise lands in active, a fall in inactive.
  a_event_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (rose_q || fell_q) |->
      (rose_q && code_q == tid_pkg::StActive) ||
      (fell_q && code_q == tid_pkg::StInactive))
    else $error("event with wrong state");

  // Reported result state matches the committed state when nothing is pending.
  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !in_vld_q |-> code_q == state_q)
    else $error("result state differs from machine state");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the timed input debouncer
// Drives timestamped level samples through the input channel and compares
// every result against a cycle-free model of the five-state machine. The
// run covers directed threshold, wrap and register extremes, a full result
// stall, and random bounce traffic under three idle mixes.
// ----------------------------------------------------------------------------
module testbench;

  // Result of one sample as the model sees it.
  typedef struct packed {
    logic                      is_active;
    logic [tid_pkg::CodeW-1:0] state_code;
    logic                      rose;
    logic                      fell;
  } sample_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_valid_i  = 1'b0;
  logic                      cfg_ready_o;
  logic [tid_pkg::TimeW-1:0] cfg_data_i   = '0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic                      raw_level_i  = 1'b0;
  logic [tid_pkg::TimeW-1:0] time_us_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic                      is_active_o;
  logic [tid_pkg::CodeW-1:0] state_code_o;
  logic                      rose_o;
  logic                      fell_o;

  timed_input_debouncer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_level_i  (raw_level_i),
    .time_us_i    (time_us_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_active_o  (is_active_o),
    .state_code_o (state_code_o),
    .rose_o       (rose_o),
    .fell_o       (fell_o)
  );

  // 20 ns period
  initial forever #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model state: machine state, time of the last state change and the
  // debounce register as the bench has written it.
  // --------------------------------------------------------------------------
  tid_pkg::state_e           mdl_state       = tid_pkg::StUnknown;
  logic [tid_pkg::TimeW-1:0] mdl_change_us   = '0;
  logic [tid_pkg::TimeW-1:0] mdl_debounce_us = tid_pkg::DebounceResetUs;

  // Results predicted at input transfer, oldest first.
  sample_result_t   pending_results[$];

  // Idle mix and stall control, shared between the stimulus and the sink.
  int unsigned      sender_idle_pct   = 0;
  int unsigned      receiver_idle_pct = 0;
  int unsigned      hold_request      = 0;

  // Bookkeeping for the summary and the verdict.
  int unsigned               mismatches      = 0;
  int unsigned               samples_sent    = 0;
  int unsigned               results_checked = 0;
  int unsigned               rise_count      = 0;
  int unsigned               fall_count      = 0;
  int unsigned               cfg_writes      = 0;
  bit                        last_level      = 1'b0;
  logic [tid_pkg::TimeW-1:0] last_time_us    = '0;

  // --------------------------------------------------------------------------
  // Debounce step on the model state. Any state change latches the sample
  // time; a pending state confirms only on a repeat of its level once the
  // wrapping elapsed time is strictly past the debounce time.
  // --------------------------------------------------------------------------
  function automatic sample_result_t debounce_step(bit level,
                                                   logic [tid_pkg::TimeW-1:0] now_us);
    sample_result_t            res;
    logic [tid_pkg::TimeW-1:0] elapsed;
    bit                        settled;
    tid_pkg::state_e           next;
    elapsed = now_us - mdl_change_us;
    settled = elapsed > mdl_debounce_us;
    next    = mdl_state;
    res     = '0;
    case (mdl_state)
      tid_pkg::StActivating: begin
        if (level) begin
          if (settled) begin
            next     = tid_pkg::StActive;
            res.rose = 1'b1;
          end
        end else begin
          next = tid_pkg::StInactive;
        end
      end
      tid_pkg::StActive: begin
        if (!level) next = tid_pkg::StInactivating;
      end
      tid_pkg::StInactivating: begin
        if (level) begin
          next = tid_pkg::StActive;
        end else if (settled) begin
          next     = tid_pkg::StInactive;
          res.fell = 1'b1;
        end
      end
      tid_pkg::StInactive: begin
        if (level) next = tid_pkg::StActivating;
      end
      default: begin
        // unknown leaves only through a high sample
        next = level ? tid_pkg::StActivating : tid_pkg::StUnknown;
      end
    endcase
    if (next != mdl_state) mdl_change_us = now_us;
    mdl_state      = next;
    res.state_code = next;
    res.is_active  = (next == tid_pkg::StActive) || (next == tid_pkg::StInactivating);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sample source: optional idle gap, then hold valid until the transfer.
  // Valid stays high on exit so back-to-back samples never drop it.
  // --------------------------------------------------------------------------
  task automatic send_sample(bit level, logic [tid_pkg::TimeW-1:0] now_us);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_level_i <= level;
    time_us_i   <= now_us;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(debounce_step(level, now_us));
    samples_sent++;
    last_level   = level;
    last_time_us = now_us;
  endtask

  // Drop valid and wait until every predicted result is back, then wait on
  // so that both pipeline stages are surely empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; only called with the block drained.
  task automatic write_debounce(logic [tid_pkg::TimeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mdl_debounce_us = value;
    cfg_writes++;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: checks each output transfer against the oldest prediction,
  // then decides ready for the next edge. A hold request turns into a long
  // run of ready low, counted down here.
  // --------------------------------------------------------------------------
  initial begin
    sample_result_t got;
    sample_result_t want;
    int unsigned    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{is_active_o, state_code_o, rose_o, fell_o};
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("%0t: result with nothing expected: %p", $time, got));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.rose) rise_count++;
          if (got.fell) fall_count++;
          if (got.is_active !== want.is_active || got.state_code !== want.state_code ||
              got.rose !== want.rose || got.fell !== want.fell)
            note_mismatch($sformatf(
              "%0t: result %0d: exp a=%0b s=%0d r=%0b f=%0b, got a=%0b s=%0d r=%0b f=%0b",
              $time, results_checked, want.is_active, want.state_code, want.rose, want.fell,
              got.is_active, got.state_code, got.rose, got.fell));
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests. Order matters: the unknown state is only reachable
  // right after reset, and each test starts where the previous one left
  // the machine.
  // --------------------------------------------------------------------------

  // Low samples keep the machine unknown; the first high one arms it.
  task automatic test_unknown_start();
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd10);
  endtask

  // Reset debounce time of 500 us, change time 10: equal elapsed must not
  // confirm, one more microsecond must. Also bounce back from inactivating
  // and a bounce while activating.
  task automatic test_confirm_threshold();
    send_sample(1'b1, 32'd510);   // elapsed 500: still pending
    send_sample(1'b1, 32'd511);   // rise
    send_sample(1'b1, 32'd5000);
    send_sample(1'b0, 32'd6000);  // inactivating
    send_sample(1'b1, 32'd6100);  // back to active, no event
    send_sample(1'b0, 32'd6200);
    send_sample(1'b0, 32'd6700);  // elapsed 500: still pending
    send_sample(1'b0, 32'd6701);  // fall
    send_sample(1'b0, 32'd9000);
    send_sample(1'b1, 32'd9100);  // activating
    send_sample(1'b0, 32'd9200);  // bounce: straight to inactive
  endtask

  // Pending across the 2^32 wrap, boundary hit exactly.
  task automatic test_timestamp_wrap();
    send_sample(1'b1, 32'hFFFF_FF00);
    send_sample(1'b1, 32'h0000_00F4);  // elapsed 500
    send_sample(1'b1, 32'h0000_00F5);  // rise
  endtask

  // Zero debounce: same timestamp never confirms, the next microsecond does.
  task automatic test_zero_debounce();
    drain_results();
    write_debounce('0);
    send_sample(1'b0, 32'h0000_1000);
    send_sample(1'b0, 32'h0000_1000);
    send_sample(1'b0, 32'h0000_1001);  // fall
  endtask

  // All-ones debounce: even the largest elapsed time cannot confirm.
  task automatic test_max_debounce();
    drain_results();
    write_debounce('1);
    send_sample(1'b1, 32'h0000_2000);
    send_sample(1'b1, 32'h0000_1FFF);  // elapsed all ones: still pending
    send_sample(1'b0, 32'h0000_3000);
  endtask

  // Random sample close to real switch behavior: mostly the level holds,
  // timestamps creep forward, land near the confirm boundary, or jump.
  task automatic send_random_sample();
    bit                        level;
    logic [tid_pkg::TimeW-1:0] t;
    level = ($urandom_range(99) < 80) ? last_level : !last_level;
    case ($urandom_range(7))
      0, 1:    t = last_time_us + $urandom_range(3);
      2, 3:    t = last_time_us + $urandom_range(mdl_debounce_us >> 2);
      4, 5:    t = mdl_change_us + mdl_debounce_us - 1 + $urandom_range(2);
      6:       t = $urandom;
      default: t = last_time_us + mdl_debounce_us + 1;
    endcase
    send_sample(level, t);
  endtask

  // Random bounce traffic in four segments, each with its own debounce time.
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned count);
    logic [tid_pkg::TimeW-1:0] deb;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    for (int seg = 0; seg < 4; seg++) begin
      drain_results();
      case ($urandom_range(6))
        0:       deb = '0;
        1:       deb = $urandom_range(15);
        2:       deb = tid_pkg::DebounceResetUs;
        3:       deb = $urandom_range(5000);
        4:       deb = $urandom;
        5:       deb = '1;
        default: deb = $urandom_range(200);
      endcase
      write_debounce(deb);
      for (int n = 0; n < count / 4; n++) send_random_sample();
    end
    drain_results();
  endtask

  // Long result stall while samples keep coming: both stages fill and the
  // input stalls. Then the source pauses until everything is back.
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    drain_results();
    write_debounce(32'd20);
    hold_request = 80;
    for (int n = 0; n < 40; n++) send_random_sample();
    drain_results();
    for (int n = 0; n < 10; n++) send_random_sample();
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests and verdict.
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unknown_start();
    test_confirm_threshold();
    test_timestamp_wrap();
    test_zero_debounce();
    test_max_debounce();
    test_backpressure();
    test_random_traffic(11, 77, 425);
    test_random_traffic(77, 11, 425);
    test_random_traffic(0, 0, 425);

    drain_results();
    repeat (8) @(posedge clk_i);
    mismatches += pending_results.size();

    $display("Covered %0d samples, %0d results checked, %0d rises, %0d falls.",
             samples_sent, results_checked, rise_count, fall_count);
    $display("Debounce register written %0d times; %0d mismatches.", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
